FILE: design/glcd_pkg.sv
// Shared types and codes for the glyph-to-page LCD writer.
// Request/response word layouts, mode and command codes, font header offsets.
// No dependencies.
`default_nettype none

package glcd_pkg;

   localparam int FONT_ADDR_W = 13;
   localparam int GLYPH_IDX_W = 7;

   typedef struct packed {
      logic [2:0]  mode;
      logic [12:0] font_addr;
      logic [7:0]  font_byte;
      logic [7:0]  column;
      logic [7:0]  line;
      logic [7:0]  character;
      logic [7:0]  spacer_height;
   } glcd_req_type;

   typedef struct packed {
      logic [1:0] command_kind;
      logic [7:0] command_value;
      logic       last;
   } glcd_rsp_type;

   localparam logic [2:0] MODE_LOAD   = 3'd0;
   localparam logic [2:0] MODE_GOTO   = 3'd1;
   localparam logic [2:0] MODE_PUTC   = 3'd2;
   localparam logic [2:0] MODE_SPACER = 3'd3;
   localparam logic [2:0] MODE_START  = 3'd4;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_PAGE  = 2'd1;
   localparam logic [1:0] KIND_COL   = 2'd2;
   localparam logic [1:0] KIND_START = 2'd3;

   localparam logic       REG_FONT_BASE = 1'b0;

   localparam logic [7:0] CHAR_FIRST     = 8'd32;
   localparam logic [7:0] CHAR_LIMIT     = 8'd128;
   localparam logic [1:0] HDR_HEIGHT_OFS = 2'd2;
   localparam logic [1:0] HDR_GLYPH_OFS  = 2'd3;
   localparam logic [7:0] ONE_PAGE_PX    = 8'd8;
   localparam logic [7:0] TWO_PAGE_PX    = 8'd16;
   localparam logic [1:0] MAX_PAGES      = 2'd3;

endpackage

`default_nettype wire

FILE: design/glcd_mod_add.sv
// Shared modular adder: (a + b + cin) mod MODULUS, for a + b + cin < 2*MODULUS.
// Used for every font store address step. No package dependency.
`default_nettype none

module glcd_mod_add #(
   parameter int MODULUS = 8192,
   parameter int W       = 13
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         cin,
   output logic [W-1:0] r
);

   logic [W:0] sum;
   logic [W:0] diff;

   assign sum  = {1'b0, a} + {1'b0, b} + (W+1)'(cin);
   assign diff = sum - (W+1)'(MODULUS);
   assign r    = (sum >= (W+1)'(MODULUS)) ? diff[W-1:0] : sum[W-1:0];

endmodule

`default_nettype wire

FILE: design/glyph_to_page_lcd_writer_core.sv
// Glyph-to-page LCD writer top level: font store, sequencer, output register, APB register.
// Depends on glcd_pkg and glcd_mod_add.
// Flow: one item at a time; req_stall is high while an item is in work. The single modular
// adder steps the font store addresses, and the store port gives one read per cycle. With
// FONT_BYTES below 8192, store and font_base addresses are first reduced bit by bit through
// the same adder before a load or a character. Output stalls hold the emitting states.
`default_nettype none

module glyph_to_page_lcd_writer_core #(
   parameter int FONT_BYTES      = 8192,
   parameter int MAX_GLYPH_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  glcd_pkg::glcd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output glcd_pkg::glcd_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   import glcd_pkg::*;

   localparam int AW       = $clog2(FONT_BYTES);
   localparam int WW       = $clog2(MAX_GLYPH_WIDTH + 1);
   localparam bit NEED_RED = FONT_BYTES < (1 << FONT_ADDR_W);

   typedef enum logic [4:0] {
      S_IDLE, S_RED, S_WR, S_HDR0, S_HDR1, S_HGT, S_DBL, S_ADD, S_ADD3,
      S_GADDR, S_WID, S_CRD, S_CEMIT, S_BLANK, S_PG, S_COL, S_END, S_SEQ
   } state_type;

   state_type              state_ff;
   glcd_req_type           item_ff;
   logic                   rsp_valid_ff;
   glcd_rsp_type           rsp_data_ff;
   logic [7:0]             cursor_col_ff;
   logic [7:0]             cursor_page_ff;
   logic [FONT_ADDR_W-1:0] font_base_ff;
   logic [FONT_ADDR_W-1:0] src_ff;
   logic [3:0]             cnt_ff;
   logic [GLYPH_IDX_W-1:0] glyph_ff;
   logic [AW-1:0]          acc_ff;
   logic [AW-1:0]          base_ff;
   logic [AW-1:0]          addr_ff;
   logic [AW-1:0]          pstart_ff;
   logic [7:0]             bpg_ff;
   logic [4:0]             stride_ff;
   logic [1:0]             pages_ff;
   logic [1:0]             page_ff;
   logic [WW-1:0]          width_ff;
   logic [WW-1:0]          remain_ff;
   logic [2:0]             seq_ff;

   logic [7:0]             font_store_ff [FONT_BYTES];
   logic [7:0]             rd_data_ff;

   logic [AW-1:0]          unit_a;
   logic [AW-1:0]          unit_b;
   logic                   unit_cin;
   logic [AW-1:0]          unit_r;

   logic                   rd_en_c;
   logic [AW-1:0]          rd_addr_c;
   logic                   wr_en_c;
   logic                   slot_free;
   logic                   emit_c;
   logic [WW-1:0]          width_sat_c;
   logic [1:0]             hgt_pages_c;
   logic [4:0]             hgt_stride_c;

   logic [1:0]             seq_kind_c;
   logic [7:0]             seq_value_c;
   logic                   seq_last_c;
   logic [2:0]             seq_last_idx_c;

   function automatic glcd_rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] value,
                                             input logic last);
      glcd_rsp_type w;
      w.command_kind  = kind;
      w.command_value = value;
      w.last          = last;
      return w;
   endfunction

   glcd_mod_add #(
      .MODULUS (FONT_BYTES),
      .W       (AW)
   ) u_mod_add (
      .a   (unit_a),
      .b   (unit_b),
      .cin (unit_cin),
      .r   (unit_r)
   );

   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign emit_c       = slot_free && (state_ff == S_CEMIT || state_ff == S_BLANK ||
                                       state_ff == S_PG || state_ff == S_COL ||
                                       state_ff == S_END || state_ff == S_SEQ);
   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == REG_FONT_BASE) ? 32'(font_base_ff) : '0;

   assign width_sat_c  = (rd_data_ff > 8'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH)
                                                             : WW'(rd_data_ff);
   assign hgt_stride_c = rd_data_ff[7:3];
   assign hgt_pages_c  = (hgt_stride_c == 5'd0) ? 2'd1 :
                         (hgt_stride_c > 5'(MAX_PAGES)) ? MAX_PAGES : hgt_stride_c[1:0];

   // adder operand select
   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_cin = 1'b0;
      unique case (state_ff)
         S_RED: begin
            unit_a   = acc_ff;
            unit_b   = acc_ff;
            unit_cin = src_ff[cnt_ff];
         end
         S_HDR1: begin
            unit_a = base_ff;
            unit_b = AW'(HDR_HEIGHT_OFS);
         end
         S_DBL: begin
            unit_a = acc_ff;
            unit_b = acc_ff;
         end
         S_ADD: begin
            unit_a = acc_ff;
            unit_b = AW'(bpg_ff);
         end
         S_ADD3: begin
            unit_a = acc_ff;
            unit_b = AW'(HDR_GLYPH_OFS);
         end
         S_GADDR: begin
            unit_a = base_ff;
            unit_b = acc_ff;
         end
         S_WID: begin
            unit_a = addr_ff;
            unit_b = AW'(1);
         end
         S_CRD: begin
            unit_a = addr_ff;
            unit_b = AW'(stride_ff);
         end
         S_BLANK: begin
            unit_a = pstart_ff;
            unit_b = AW'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      rd_en_c   = 1'b0;
      rd_addr_c = addr_ff;
      unique case (state_ff)
         S_HDR0: begin
            rd_en_c   = 1'b1;
            rd_addr_c = base_ff;
         end
         S_HDR1, S_GADDR: begin
            rd_en_c   = 1'b1;
            rd_addr_c = unit_r;
         end
         S_CRD: begin
            rd_en_c   = 1'b1;
            rd_addr_c = addr_ff;
         end
         default: ;
      endcase
   end

   assign wr_en_c = (state_ff == S_WR);

   // short command lists: goto, spacer, start line
   always_comb begin
      seq_kind_c     = KIND_DATA;
      seq_value_c    = '0;
      seq_last_idx_c = 3'd1;
      unique case (item_ff.mode)
         MODE_GOTO: begin
            seq_last_idx_c = 3'd1;
            seq_kind_c     = (seq_ff == 3'd0) ? KIND_PAGE : KIND_COL;
            seq_value_c    = (seq_ff == 3'd0) ? item_ff.line : item_ff.column;
         end
         MODE_START: begin
            seq_last_idx_c = 3'd0;
            seq_kind_c     = KIND_START;
            seq_value_c    = item_ff.line;
         end
         MODE_SPACER: begin
            if (item_ff.spacer_height > TWO_PAGE_PX) begin
               seq_last_idx_c = 3'd7;
            end else if (item_ff.spacer_height > ONE_PAGE_PX) begin
               seq_last_idx_c = 3'd4;
            end else begin
               seq_last_idx_c = 3'd1;
            end
            unique case (seq_ff)
               3'd1: begin
                  seq_kind_c  = KIND_PAGE;
                  seq_value_c = cursor_page_ff + 8'd1;
               end
               3'd4: begin
                  seq_kind_c  = KIND_PAGE;
                  seq_value_c = cursor_page_ff + 8'd2;
               end
               3'd2, 3'd5: begin
                  seq_kind_c  = KIND_COL;
                  seq_value_c = cursor_col_ff;
               end
               default: begin
                  seq_kind_c  = KIND_DATA;
                  seq_value_c = '0;
               end
            endcase
            if (seq_ff == seq_last_idx_c) begin
               seq_kind_c  = KIND_PAGE;
               seq_value_c = cursor_page_ff;
            end
         end
         default: ;
      endcase
   end

   assign seq_last_c = (seq_ff == seq_last_idx_c);

   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         font_store_ff[acc_ff] <= item_ff.font_byte;
      end
      if (rd_en_c) begin
         rd_data_ff <= font_store_ff[rd_addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_base_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FONT_BASE)) begin
         font_base_ff <= pwdata[FONT_ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         cursor_col_ff  <= '0;
         cursor_page_ff <= '0;
      end else begin
         if (emit_c) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  seq_ff   <= '0;
                  acc_ff   <= '0;
                  cnt_ff   <= 4'(FONT_ADDR_W - 1);
                  glyph_ff <= GLYPH_IDX_W'(req_data.character - CHAR_FIRST);
                  unique case (req_data.mode)
                     MODE_LOAD: begin
                        src_ff <= req_data.font_addr;
                        if (NEED_RED) begin
                           state_ff <= S_RED;
                        end else begin
                           acc_ff   <= AW'(req_data.font_addr);
                           state_ff <= S_WR;
                        end
                     end
                     MODE_PUTC: begin
                        src_ff  <= font_base_ff;
                        base_ff <= AW'(font_base_ff);
                        if (req_data.character >= CHAR_FIRST &&
                            req_data.character < CHAR_LIMIT) begin
                           state_ff <= NEED_RED ? S_RED : S_HDR0;
                        end
                     end
                     MODE_GOTO, MODE_SPACER, MODE_START: begin
                        state_ff <= S_SEQ;
                     end
                     default: ;
                  endcase
               end
            end
            S_RED: begin
               acc_ff <= unit_r;
               if (cnt_ff == 4'd0) begin
                  if (item_ff.mode == MODE_LOAD) begin
                     state_ff <= S_WR;
                  end else begin
                     base_ff  <= unit_r;
                     state_ff <= S_HDR0;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 4'd1;
               end
            end
            S_WR: begin
               state_ff <= S_IDLE;
            end
            S_HDR0: begin
               state_ff <= S_HDR1;
            end
            S_HDR1: begin
               bpg_ff   <= rd_data_ff;
               state_ff <= S_HGT;
            end
            S_HGT: begin
               stride_ff <= hgt_stride_c;
               pages_ff  <= hgt_pages_c;
               acc_ff    <= '0;
               cnt_ff    <= 4'(GLYPH_IDX_W - 1);
               state_ff  <= S_DBL;
            end
            S_DBL: begin
               acc_ff   <= unit_r;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (glyph_ff[cnt_ff[2:0]]) begin
                  acc_ff <= unit_r;
               end
               if (cnt_ff == 4'd0) begin
                  state_ff <= S_ADD3;
               end else begin
                  cnt_ff   <= cnt_ff - 4'd1;
                  state_ff <= S_DBL;
               end
            end
            S_ADD3: begin
               acc_ff   <= unit_r;
               state_ff <= S_GADDR;
            end
            S_GADDR: begin
               addr_ff  <= unit_r;
               state_ff <= S_WID;
            end
            S_WID: begin
               width_ff  <= width_sat_c;
               remain_ff <= width_sat_c;
               addr_ff   <= unit_r;
               pstart_ff <= unit_r;
               page_ff   <= '0;
               state_ff  <= (width_sat_c != '0) ? S_CRD : S_BLANK;
            end
            S_CRD: begin
               addr_ff  <= unit_r;
               state_ff <= S_CEMIT;
            end
            S_CEMIT: begin
               if (slot_free) begin
                  rsp_data_ff  <= make_rsp(KIND_DATA, rd_data_ff, 1'b0);
                  remain_ff    <= remain_ff - WW'(1);
                  state_ff     <= (remain_ff == WW'(1)) ? S_BLANK : S_CRD;
               end
            end
            S_BLANK: begin
               if (slot_free) begin
                  rsp_data_ff  <= make_rsp(KIND_DATA, 8'd0, 1'b0);
                  if (page_ff == pages_ff - 2'd1) begin
                     state_ff <= S_END;
                  end else begin
                     page_ff   <= page_ff + 2'd1;
                     addr_ff   <= unit_r;
                     pstart_ff <= unit_r;
                     state_ff  <= S_PG;
                  end
               end
            end
            S_PG: begin
               if (slot_free) begin
                  rsp_data_ff  <= make_rsp(KIND_PAGE, cursor_page_ff + 8'(page_ff), 1'b0);
                  state_ff     <= S_COL;
               end
            end
            S_COL: begin
               if (slot_free) begin
                  rsp_data_ff  <= make_rsp(KIND_COL, cursor_col_ff, 1'b0);
                  remain_ff    <= width_ff;
                  state_ff     <= (width_ff != '0) ? S_CRD : S_BLANK;
               end
            end
            S_END: begin
               if (slot_free) begin
                  rsp_data_ff   <= make_rsp(KIND_PAGE, cursor_page_ff, 1'b1);
                  cursor_col_ff <= cursor_col_ff + 8'(width_ff) + 8'd1;
                  state_ff      <= S_IDLE;
               end
            end
            S_SEQ: begin
               if (slot_free) begin
                  rsp_data_ff  <= make_rsp(seq_kind_c, seq_value_c, seq_last_c);
                  if (seq_last_c) begin
                     if (item_ff.mode == MODE_GOTO) begin
                        cursor_page_ff <= item_ff.line;
                        cursor_col_ff  <= item_ff.column;
                     end else if (item_ff.mode == MODE_SPACER) begin
                        cursor_col_ff <= cursor_col_ff + 8'd1;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     seq_ff <= seq_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: dv/glcd_command_checker.sv
// Command-word checker for the glyph-to-page LCD writer: tracks the font store, cursor and
// font base from the request and APB ports, predicts each command word and compares it.
// Depends on glcd_pkg.
module glcd_command_checker #(
   parameter int FONT_BYTES      = 8192,
   parameter int MAX_GLYPH_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  glcd_pkg::glcd_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  glcd_pkg::glcd_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   input  logic                   pready,
   output int                     pending,
   output int                     fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import glcd_pkg::*;

   logic [7:0]   glyph_mem [FONT_BYTES];
   logic [7:0]   cursor_col;
   logic [7:0]   cursor_pg;
   logic [12:0]  font_base_q;
   glcd_rsp_type cmd_expect [$];
   int           fails;

   function automatic logic [7:0] font_byte_at(int ofs);
      return glyph_mem[(int'(font_base_q) + ofs) % FONT_BYTES];
   endfunction

   function automatic void push_cmd(logic [1:0] kind, int value);
      glcd_rsp_type cmd;
      cmd.command_kind  = kind;
      cmd.command_value = 8'(value);
      cmd.last          = 1'b0;
      cmd_expect.push_back(cmd);
   endfunction

   function automatic void predict_commands(glcd_req_type w);
      int n0;
      int chr;
      int ofs;
      int idx;
      int width;
      int stride;
      int npg;
      n0 = cmd_expect.size();
      case (w.mode)
         MODE_LOAD: begin
            glyph_mem[int'(w.font_addr) % FONT_BYTES] = w.font_byte;
         end
         MODE_GOTO: begin
            push_cmd(KIND_PAGE, w.line);
            cursor_pg = w.line;
            push_cmd(KIND_COL, w.column);
            cursor_col = w.column;
         end
         MODE_PUTC: begin
            chr = int'(w.character);
            if (chr >= int'(CHAR_FIRST) && chr < int'(CHAR_LIMIT)) begin
               ofs = (chr - int'(CHAR_FIRST)) * int'(font_byte_at(0)) + int'(HDR_GLYPH_OFS);
               width = int'(font_byte_at(ofs));
               if (width > MAX_GLYPH_WIDTH) width = MAX_GLYPH_WIDTH;
               stride = int'(font_byte_at(int'(HDR_HEIGHT_OFS))) / int'(ONE_PAGE_PX);
               npg = (stride < 1) ? 1 : ((stride > int'(MAX_PAGES)) ? int'(MAX_PAGES) : stride);
               for (int p = 0; p < npg; p++) begin
                  idx = ofs + 1 + p;
                  if (p > 0) begin
                     push_cmd(KIND_PAGE, int'(cursor_pg) + p);
                     push_cmd(KIND_COL, cursor_col);
                  end
                  for (int c = 0; c < width; c++) begin
                     push_cmd(KIND_DATA, font_byte_at(idx));
                     idx += stride;
                  end
                  push_cmd(KIND_DATA, 0);
               end
               cursor_col = 8'(int'(cursor_col) + width + 1);
               push_cmd(KIND_PAGE, cursor_pg);
            end
         end
         MODE_SPACER: begin
            push_cmd(KIND_DATA, 0);
            if (w.spacer_height > ONE_PAGE_PX) begin
               push_cmd(KIND_PAGE, int'(cursor_pg) + 1);
               push_cmd(KIND_COL, cursor_col);
               push_cmd(KIND_DATA, 0);
            end
            if (w.spacer_height > TWO_PAGE_PX) begin
               push_cmd(KIND_PAGE, int'(cursor_pg) + 2);
               push_cmd(KIND_COL, cursor_col);
               push_cmd(KIND_DATA, 0);
            end
            cursor_col = cursor_col + 8'd1;
            push_cmd(KIND_PAGE, cursor_pg);
         end
         MODE_START: begin
            push_cmd(KIND_START, w.line);
         end
         default: ;
      endcase
      if (cmd_expect.size() > n0) cmd_expect[cmd_expect.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      glcd_rsp_type want;
      if (reset) begin
         cmd_expect.delete();
         cursor_col  = '0;
         cursor_pg   = '0;
         font_base_q = '0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {REG_FONT_BASE, 2'b00})
            font_base_q = pwdata[12:0];
         if (req_valid && !req_stall) predict_commands(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (cmd_expect.size() == 0) begin
               $error("unexpected command word: kind %0d value %0h last %0b",
                      rsp_data.command_kind, rsp_data.command_value, rsp_data.last);
               fails++;
            end else begin
               want = cmd_expect.pop_front();
               if (rsp_data.command_kind !== want.command_kind) begin
                  $error("command_kind: expected %0d, got %0d",
                         want.command_kind, rsp_data.command_kind);
                  fails++;
               end
               if (rsp_data.command_value !== want.command_value) begin
                  $error("command_value: expected %0h, got %0h",
                         want.command_value, rsp_data.command_value);
                  fails++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  fails++;
               end
            end
         end
      end
      pending    <= cmd_expect.size();
      fail_count <= fails;
   end

endmodule

FILE: dv/tb_glyph_to_page_lcd_writer_core.sv
// Testbench top for glyph_to_page_lcd_writer_core: clock, reset, request/response and APB
// stimulus, receiver stalls and the verdict. Depends on glcd_pkg and glcd_command_checker.
module tb_glyph_to_page_lcd_writer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import glcd_pkg::*;

   localparam int FONT_BYTES      = 8192;
   localparam int MAX_GLYPH_WIDTH = 16;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int HOLD_CYCLES     = 400;
   localparam logic [2:0] FONT_BASE_ADDR = {REG_FONT_BASE, 2'b00};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   glcd_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   glcd_rsp_type rsp_data;
   logic         psel      = 1'b0;
   logic         penable   = 1'b0;
   logic         pwrite    = 1'b0;
   logic [2:0]   paddr     = '0;
   logic [31:0]  pwdata    = '0;
   logic [31:0]  prdata;
   logic         pready;

   int          pending;
   int          fail_count;
   int          cycle_count  = 0;
   int          words_sent   = 0;
   int          req_idle_pct = 37;
   int          rsp_idle_pct = 66;
   bit          hold_now     = 1'b0;
   logic [12:0] cur_base     = '0;
   logic [7:0]  font_img [FONT_BYTES];
   bit          font_set [FONT_BYTES];
   logic [7:0]  char_set [8];

   glyph_to_page_lcd_writer_core #(
      .FONT_BYTES     (FONT_BYTES),
      .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
   ) dut (.*);

   glcd_command_checker #(
      .FONT_BYTES     (FONT_BYTES),
      .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
   ) checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver stalls, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic glcd_req_type random_word(logic [2:0] mode);
      glcd_req_type w;
      w.mode          = mode;
      w.font_addr     = 13'($urandom);
      w.font_byte     = 8'($urandom);
      w.column        = 8'($urandom);
      w.line          = 8'($urandom);
      w.character     = 8'($urandom);
      w.spacer_height = 8'($urandom);
      return w;
   endfunction

   function automatic logic [7:0] img_at(int ofs);
      return font_img[(int'(cur_base) + ofs) % FONT_BYTES];
   endfunction

   function automatic logic [7:0] pick_height();
      case ($urandom_range(5))
         0: return 8'($urandom_range(7));
         1: return 8'($urandom_range(15, 8));
         2: return 8'($urandom_range(23, 16));
         3: return 8'($urandom_range(31, 24));
         default: return 8'($urandom_range(255, 32));
      endcase
   endfunction

   task automatic send_word(input glcd_req_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic load_byte(input int addr, input logic [7:0] val);
      glcd_req_type w;
      int a;
      a = addr % FONT_BYTES;
      w = random_word(MODE_LOAD);
      w.font_addr = 13'(a);
      w.font_byte = val;
      font_img[a] = val;
      font_set[a] = 1'b1;
      send_word(w);
   endtask

   task automatic ensure_byte(input int ofs, input logic [7:0] val);
      int a;
      a = (int'(cur_base) + ofs) % FONT_BYTES;
      if (!font_set[a]) load_byte(a, val);
   endtask

   // loads whatever part of the glyph is still missing, then draws it
   task automatic draw_char(input logic [7:0] ch);
      glcd_req_type w;
      int ofs;
      int width;
      int stride;
      int npg;
      if (ch >= CHAR_FIRST && ch < CHAR_LIMIT) begin
         ensure_byte(0, 8'($urandom));
         ensure_byte(int'(HDR_HEIGHT_OFS), pick_height());
         ofs = (int'(ch) - int'(CHAR_FIRST)) * int'(img_at(0)) + int'(HDR_GLYPH_OFS);
         ensure_byte(ofs, ($urandom_range(9) == 0) ? 8'($urandom_range(255, 17))
                                                    : 8'($urandom_range(16)));
         width = int'(img_at(ofs));
         if (width > MAX_GLYPH_WIDTH) width = MAX_GLYPH_WIDTH;
         stride = int'(img_at(int'(HDR_HEIGHT_OFS))) / int'(ONE_PAGE_PX);
         npg = (stride < 1) ? 1 : ((stride > int'(MAX_PAGES)) ? int'(MAX_PAGES) : stride);
         for (int p = 0; p < npg; p++)
            for (int c = 0; c < width; c++)
               ensure_byte(ofs + 1 + p + c * stride, 8'($urandom));
      end
      w = random_word(MODE_PUTC);
      w.character = ch;
      send_word(w);
   endtask

   task automatic goto_pos(input logic [7:0] col, input logic [7:0] ln);
      glcd_req_type w;
      w = random_word(MODE_GOTO);
      w.column = col;
      w.line   = ln;
      send_word(w);
   endtask

   task automatic spacer(input logic [7:0] h);
      glcd_req_type w;
      w = random_word(MODE_SPACER);
      w.spacer_height = h;
      send_word(w);
   endtask

   task automatic start_line(input logic [7:0] ln);
      glcd_req_type w;
      w = random_word(MODE_START);
      w.line = ln;
      send_word(w);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_font_base(input logic [12:0] v);
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= FONT_BASE_ADDR;
      pwdata  <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_base = v;
   endtask

   // quota counts every word sent, font loads included
   task automatic random_phase(input int quota);
      int first;
      int pick;
      for (int i = 0; i < 8; i++) char_set[i] = 8'($urandom_range(127, 32));
      first = words_sent;
      while (words_sent - first < quota) begin
         pick = $urandom_range(99);
         if (pick < 50) draw_char(char_set[$urandom_range(7)]);
         else if (pick < 55) draw_char(8'($urandom_range(127, 32)));
         else if (pick < 65) goto_pos(8'($urandom), 8'($urandom));
         else if (pick < 75) spacer($urandom_range(1) ? 8'($urandom_range(24)) : 8'($urandom));
         else if (pick < 80) start_line(8'($urandom));
         else if (pick < 88) load_byte($urandom_range(FONT_BYTES - 1), 8'($urandom));
         else if (pick < 90) begin
            if ($urandom_range(1)) load_byte(int'(cur_base), 8'($urandom));
            else load_byte(int'(cur_base) + int'(HDR_HEIGHT_OFS), pick_height());
         end else if (pick < 95) begin
            draw_char($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 128)));
         end else begin
            send_word(random_word(3'($urandom_range(7, 5))));
         end
      end
   endtask

   initial begin
      logic [7:0] marks [6];
      marks = '{8'd0, 8'd8, 8'd9, 8'd16, 8'd17, 8'd255};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_font_base(13'd0);
      // tiny font: 3 bytes per glyph, height below one page, wide glyph for the space
      load_byte(0, 8'd3);
      load_byte(int'(HDR_HEIGHT_OFS), 8'd4);
      load_byte(3, 8'd20);
      load_byte(4, 8'hFF);
      goto_pos(8'd255, 8'd255);
      draw_char(CHAR_FIRST);
      foreach (marks[i]) spacer(marks[i]);
      start_line(8'd0);
      start_line(8'd255);
      draw_char(8'd0);
      draw_char(8'd31);
      draw_char(CHAR_LIMIT);
      draw_char(8'd255);
      for (int m = 5; m < 8; m++) send_word(random_word(3'(m)));
      // tall font, one-column glyph for the last code
      load_byte(int'(HDR_HEIGHT_OFS), 8'd255);
      load_byte(288, 8'd1);
      load_byte(289, 8'h81);
      load_byte(290, 8'h00);
      load_byte(291, 8'h7E);
      draw_char(8'd127);
      load_byte(FONT_BYTES - 1, 8'h5A);
      goto_pos(8'd0, 8'd0);

      hold_now = 1'b1;
      random_phase(120);

      req_idle_pct = 66;
      rsp_idle_pct = 37;
      set_font_base(13'h1FFF);
      random_phase(120);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_font_base(13'($urandom));
      random_phase(140);

      wait_idle();
      if (pending != 0) $error("%0d command words never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: glyph_to_page_lcd_writer_core.f
design/glcd_pkg.sv
design/glcd_mod_add.sv
design/glyph_to_page_lcd_writer_core.sv
dv/glcd_command_checker.sv
dv/tb_glyph_to_page_lcd_writer_core.sv
